// ===== rtl/core/qau_pkg.sv =====
// Shared types, constants and helper functions of the quaternion arithmetic unit.
// No dependencies; every other file of the unit but qau_if imports this package.
package qau_pkg;

    localparam int WORD_W        = 32;
    localparam int FRAC_BITS_DEF = 16;
    localparam int QDEPTH        = 4;
    localparam int ROOT_STEPS    = 33;

    typedef logic [2:0] t_action;

    localparam t_action ACT_MUL    = 3'd0;
    localparam t_action ACT_MUL_CB = 3'd1;
    localparam t_action ACT_CA_MUL = 3'd2;
    localparam t_action ACT_ROT    = 3'd3;
    localparam t_action ACT_IROT   = 3'd4;
    localparam t_action ACT_NORM   = 3'd5;

    typedef enum logic [2:0] {
        K_MUL, K_MUL_CB, K_CA_MUL, K_ROT, K_IROT, K_NORM, K_ZERO
    } t_kind;

    typedef enum logic [2:0] {
        N_IDLE, N_SQ, N_ROOT, N_DIV, N_DONE
    } t_nstate;

    typedef logic signed [WORD_W-1:0] t_word;

    typedef struct {
        t_kind kind;
        t_word a [4];
        t_word b [4];
    } t_item;

    typedef struct packed {
        logic              sat;
        logic signed [31:0] v;
    } t_clip;

    typedef struct packed {
        logic idle;
        logic done;
    } t_norm_st;

    // Operand selection of the first product stage: q[i] = a[QA_IDX[i]] * b[QB_IDX[i]].
    localparam logic [1:0] QA_IDX [16] = '{2'd0, 2'd1, 2'd2, 2'd3, 2'd1, 2'd0, 2'd2, 2'd3,
                                           2'd2, 2'd0, 2'd3, 2'd1, 2'd3, 2'd0, 2'd1, 2'd2};
    localparam logic [1:0] QB_IDX [16] = '{2'd0, 2'd1, 2'd2, 2'd3, 2'd0, 2'd1, 2'd3, 2'd2,
                                           2'd0, 2'd2, 2'd1, 2'd3, 2'd0, 2'd3, 2'd2, 2'd1};
    // Operand selection of the second rotation stage: p[i] = a[PA_IDX[i]] * t[PT_IDX[i]].
    localparam logic [1:0] PA_IDX [12] = '{2'd1, 2'd0, 2'd2, 2'd3, 2'd2, 2'd0, 2'd3, 2'd1,
                                           2'd3, 2'd0, 2'd1, 2'd2};
    localparam logic [1:0] PT_IDX [12] = '{2'd0, 2'd1, 2'd3, 2'd2, 2'd0, 2'd2, 2'd1, 2'd3,
                                           2'd0, 2'd3, 2'd2, 2'd1};

    function automatic t_kind classify(input t_action act);
        t_kind k;
        case (act)
            ACT_MUL:    k = K_MUL;
            ACT_MUL_CB: k = K_MUL_CB;
            ACT_CA_MUL: k = K_CA_MUL;
            ACT_ROT:    k = K_ROT;
            ACT_IROT:   k = K_IROT;
            ACT_NORM:   k = K_NORM;
            default:    k = K_ZERO;
        endcase
        return k;
    endfunction

    function automatic t_clip clip32(input logic signed [63:0] v);
        t_clip c;
        c.sat = 1'b1;
        if (v > 64'sd2147483647) begin
            c.v = 32'sh7fffffff;
        end else if (v < -64'sd2147483648) begin
            c.v = 32'sh80000000;
        end else begin
            c.sat = 1'b0;
            c.v   = v[31:0];
        end
        return c;
    endfunction

endpackage

// ===== rtl/core/qau_if.sv =====
// Valid/ready channel interfaces for the operation beats and the result beats.
// Depends on nothing; the port widths are those of the Q16.16 fields.
interface qau_in_if;
    logic              valid;
    logic              ready;
    logic [2:0]        action;
    logic signed [31:0] a_s;
    logic signed [31:0] a_x;
    logic signed [31:0] a_y;
    logic signed [31:0] a_z;
    logic signed [31:0] b_s;
    logic signed [31:0] b_x;
    logic signed [31:0] b_y;
    logic signed [31:0] b_z;
    modport source(output valid, action, a_s, a_x, a_y, a_z, b_s, b_x, b_y, b_z,
                   input ready);
    modport sink(input valid, action, a_s, a_x, a_y, a_z, b_s, b_x, b_y, b_z,
                 output ready);
endinterface

interface qau_out_if;
    logic              valid;
    logic              ready;
    logic signed [31:0] r_s;
    logic signed [31:0] r_x;
    logic signed [31:0] r_y;
    logic signed [31:0] r_z;
    logic              saturated;
    modport source(output valid, r_s, r_x, r_y, r_z, saturated, input ready);
    modport sink(input valid, r_s, r_x, r_y, r_z, saturated, output ready);
endinterface

// ===== rtl/core/quaternion_arithmetic_unit_core.sv =====
// Quaternion arithmetic unit in signed Q16.16: products, conjugate products, vector
// rotation and inverse rotation take one beat per cycle, while the result side is not
// stalled and no normalize is running, through the product/sum pipeline; normalize runs
// in an iterative unit (squares, one root bit per cycle, one quotient bit per cycle)
// during which later beats wait in the input queue, so results stay in order.
// Depends on qau_pkg, qau_if, qau_front and qau_back.
module quaternion_arithmetic_unit_core import qau_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    qau_in_if.sink    i_in,
    qau_out_if.source o_out
);
    t_item head;
    logic  head_valid;
    logic  pop;

    qau_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .o_head       (head),
        .o_head_valid (head_valid),
        .i_pop        (pop)
    );

    qau_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (head),
        .i_head_valid (head_valid),
        .o_pop        (pop),
        .o_out        (o_out)
    );

endmodule

// ===== rtl/core/qau_front.sv =====
// Front end: accepts operation beats, classifies the action and queues the item.
// Depends on qau_pkg and qau_in_if.
module qau_front import qau_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    qau_in_if.sink        i_in,
    output t_item         o_head,
    output logic          o_head_valid,
    input  logic          i_pop
);
    localparam int PW = $clog2(QDEPTH);

    t_item          r_q [QDEPTH];
    logic [PW-1:0]  r_wp, r_rp;
    logic [PW:0]    r_cnt;
    logic           push;

    assign i_in.ready   = (r_cnt != (PW+1)'(QDEPTH));
    assign push         = i_in.valid && i_in.ready;
    assign o_head       = r_q[r_rp];
    assign o_head_valid = (r_cnt != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp].kind <= classify(i_in.action);
            r_q[r_wp].a[0] <= i_in.a_s;
            r_q[r_wp].a[1] <= i_in.a_x;
            r_q[r_wp].a[2] <= i_in.a_y;
            r_q[r_wp].a[3] <= i_in.a_z;
            r_q[r_wp].b[0] <= i_in.b_s;
            r_q[r_wp].b[1] <= i_in.b_x;
            r_q[r_wp].b[2] <= i_in.b_y;
            r_q[r_wp].b[3] <= i_in.b_z;
        end
    end

endmodule

// ===== rtl/core/qau_norm.sv =====
// Iterative normalizer: sum of squares, bit-serial square root, four serial dividers.
// Depends on qau_pkg.
module qau_norm import qau_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_start,
    input  t_word     i_a [4],
    input  logic      i_take,
    output t_norm_st  o_st,
    output t_word     o_res [4]
);
    localparam int DW = WORD_W + FRAC_BITS;
    localparam int SW = $clog2(DW);

    t_nstate          r_state, n_state;
    t_word            r_c [4];
    logic [1:0]       r_i;
    logic [64:0]      r_acc;
    logic [65:0]      r_rad;
    logic [35:0]      r_rem;
    logic [32:0]      r_root;
    logic [SW-1:0]    r_step;
    logic [DW-1:0]    r_dvd [4];
    logic [32:0]      r_drem [4];
    logic [DW-1:0]    r_quo [4];

    logic signed [63:0] ce;
    logic [63:0]      sq;
    logic [64:0]      acc_n;
    logic [35:0]      rem_n, trial;
    logic             ge;
    logic [32:0]      root_n;
    logic [33:0]      drem_n [4];
    logic             dge [4];
    logic [31:0]      mag [4];
    logic             root_last, div_last;

    always_comb begin
        ce        = r_c[r_i];
        sq        = ce * ce;
        acc_n     = r_acc + {1'b0, sq};
        rem_n     = {r_rem[33:0], r_rad[65:64]};
        trial     = {1'b0, r_root, 2'b01};
        ge        = (rem_n >= trial);
        root_n    = {r_root[31:0], ge};
        root_last = (r_step == SW'(ROOT_STEPS - 1));
        div_last  = (r_step == SW'(DW - 1));
        for (int k = 0; k < 4; k++) begin
            drem_n[k] = {r_drem[k], r_dvd[k][DW-1]};
            dge[k]    = (drem_n[k] >= {1'b0, r_root});
            mag[k]    = r_c[k][31] ? (~r_c[k] + 32'd1) : r_c[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= N_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_st.idle = (r_state == N_IDLE);
        o_st.done = (r_state == N_DONE);
        case (r_state)
            N_IDLE: begin
                if (i_start) begin
                    n_state = N_SQ;
                end
            end
            N_SQ: begin
                if (r_i == 2'd3) begin
                    n_state = N_ROOT;
                end
            end
            N_ROOT: begin
                if (root_last) begin
                    n_state = (root_n == '0) ? N_DONE : N_DIV;
                end
            end
            N_DIV: begin
                if (div_last) begin
                    n_state = N_DONE;
                end
            end
            N_DONE: begin
                if (i_take) begin
                    n_state = N_IDLE;
                end
            end
            default: n_state = N_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            N_IDLE: begin
                if (i_start) begin
                    r_c   <= i_a;
                    r_acc <= '0;
                    r_i   <= '0;
                end
            end
            N_SQ: begin
                r_acc  <= acc_n;
                r_i    <= r_i + 2'd1;
                r_rad  <= {1'b0, acc_n};
                r_rem  <= '0;
                r_root <= '0;
                r_step <= '0;
            end
            N_ROOT: begin
                r_rad  <= {r_rad[63:0], 2'b00};
                r_rem  <= ge ? (rem_n - trial) : rem_n;
                r_root <= root_n;
                r_step <= root_last ? '0 : r_step + 1'b1;
                for (int k = 0; k < 4; k++) begin
                    r_dvd[k]  <= {mag[k], {FRAC_BITS{1'b0}}};
                    r_drem[k] <= '0;
                    r_quo[k]  <= '0;
                end
            end
            N_DIV: begin
                r_step <= r_step + 1'b1;
                for (int k = 0; k < 4; k++) begin
                    r_dvd[k]  <= {r_dvd[k][DW-2:0], 1'b0};
                    r_drem[k] <= dge[k] ? 33'(drem_n[k] - {1'b0, r_root}) : drem_n[k][32:0];
                    r_quo[k]  <= {r_quo[k][DW-2:0], dge[k]};
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            if (r_root == '0) begin
                o_res[k] = (k == 0) ? (32'sd1 <<< FRAC_BITS) : '0;
            end else begin
                o_res[k] = r_c[k][31] ? -$signed(r_quo[k][31:0]) : $signed(r_quo[k][31:0]);
            end
        end
    end

endmodule

// ===== rtl/core/qau_back.sv =====
// Back end: four-stage product/sum pipeline for products and rotations, plus the normalizer.
// Depends on qau_pkg, qau_out_if and qau_norm.
module qau_back import qau_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_item     i_head,
    input  logic      i_head_valid,
    output logic      o_pop,
    qau_out_if.source o_out
);
    function automatic logic signed [63:0] qmul(input t_word x, input t_word y);
        logic signed [63:0] xe, ye, p;
        xe = x;
        ye = y;
        p  = xe * ye;
        return p >>> FRAC_BITS;
    endfunction

    t_norm_st           nst;
    t_word              norm_res [4];
    logic               en, issue, norm_start, in_v;

    logic               r1_v, r2_v, r3_v, r4_v;
    t_kind              r1_kind, r2_kind, r3_kind, r4_kind;
    t_word              r1_a [4];
    t_word              r2_a [4];
    logic signed [63:0] r1_q [16];
    logic signed [63:0] r3_p [12];
    t_word              r1_res [4];
    t_word              r2_res [4];
    t_word              r3_res [4];
    t_word              r4_res [4];
    logic               r2_sat, r3_sat, r4_sat;

    t_word              n2_res [4];
    logic               n2_sat;
    t_word              n4_res [4];
    logic               n4_sat;
    logic [3:0]         neg0, negr, use_m, neg2;
    logic signed [63:0] sum;
    t_clip              c;
    logic signed [63:0] sum4;
    t_clip              c4;

    qau_norm #(.FRAC_BITS(FRAC_BITS)) u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (norm_start),
        .i_a     (i_head.a),
        .i_take  (nst.done && en),
        .o_st    (nst),
        .o_res   (norm_res)
    );

    assign en         = !r4_v || o_out.ready;
    assign issue      = i_head_valid && nst.idle && (i_head.kind != K_NORM);
    assign norm_start = i_head_valid && nst.idle && (i_head.kind == K_NORM);
    assign o_pop      = norm_start || (issue && en);
    assign in_v       = issue || nst.done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
        end else if (en) begin
            r1_v <= in_v;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
        end
    end

    always_comb begin
        neg0  = 4'b0000;
        negr  = 4'b0000;
        use_m = 4'b1111;
        case (r1_kind)
            K_MUL: begin
                neg0 = 4'b1110;
                negr = 4'b1000;
            end
            K_MUL_CB: negr = 4'b0110;
            K_CA_MUL: negr = 4'b0101;
            K_ROT: begin
                negr  = 4'b1000;
                use_m = 4'b1110;
            end
            K_IROT: begin
                neg0  = 4'b1110;
                negr  = 4'b0100;
                use_m = 4'b1110;
            end
            default: begin
            end
        endcase
        n2_sat = 1'b0;
        for (int k = 0; k < 4; k++) begin
            sum = '0;
            for (int j = 0; j < 4; j++) begin
                if (use_m[j]) begin
                    if ((k == 0) ? neg0[j] : negr[j]) begin
                        sum = sum - r1_q[4*k+j];
                    end else begin
                        sum = sum + r1_q[4*k+j];
                    end
                end
            end
            c         = clip32(sum);
            n2_res[k] = c.v;
            n2_sat    = n2_sat | c.sat;
        end
        if (r1_kind == K_NORM || r1_kind == K_ZERO) begin
            n2_res = r1_res;
            n2_sat = 1'b0;
        end
    end

    always_comb begin
        neg2   = (r3_kind == K_IROT) ? 4'b0101 : 4'b1000;
        n4_sat = r3_sat;
        n4_res = r3_res;
        sum4   = '0;
        c4     = '0;
        if (r3_kind == K_ROT || r3_kind == K_IROT) begin
            n4_res[0] = '0;
            for (int k = 0; k < 3; k++) begin
                sum4 = '0;
                for (int j = 0; j < 4; j++) begin
                    if (neg2[j]) begin
                        sum4 = sum4 - r3_p[4*k+j];
                    end else begin
                        sum4 = sum4 + r3_p[4*k+j];
                    end
                end
                c4          = clip32(sum4);
                n4_res[k+1] = c4.v;
                n4_sat      = n4_sat | c4.sat;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_kind <= nst.done ? K_NORM : i_head.kind;
            r1_a    <= i_head.a;
            for (int i = 0; i < 16; i++) begin
                r1_q[i] <= qmul(i_head.a[QA_IDX[i]], i_head.b[QB_IDX[i]]);
            end
            for (int k = 0; k < 4; k++) begin
                r1_res[k] <= nst.done ? norm_res[k] : '0;
            end
            r2_kind <= r1_kind;
            r2_a    <= r1_a;
            r2_res  <= n2_res;
            r2_sat  <= n2_sat;
            r3_kind <= r2_kind;
            r3_res  <= r2_res;
            r3_sat  <= r2_sat;
            for (int i = 0; i < 12; i++) begin
                r3_p[i] <= qmul(r2_a[PA_IDX[i]], r2_res[PT_IDX[i]]);
            end
            r4_kind <= r3_kind;
            r4_res  <= n4_res;
            r4_sat  <= n4_sat;
        end
    end

    assign o_out.valid     = r4_v;
    assign o_out.r_s       = r4_res[0];
    assign o_out.r_x       = r4_res[1];
    assign o_out.r_y       = r4_res[2];
    assign o_out.r_z       = r4_res[3];
    assign o_out.saturated = r4_sat;

    a_norm_no_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r4_v && r4_kind == K_NORM |-> !r4_sat)
        else $error("normalize result flagged as saturated");

    a_rot_scalar_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r4_v && (r4_kind == K_ROT || r4_kind == K_IROT) |-> r4_res[0] == '0)
        else $error("rotation result has nonzero scalar part");

    a_zero_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r4_v && r4_kind == K_ZERO |-> r4_res[1] == '0 && !r4_sat)
        else $error("unused action produced a nonzero result");

    a_norm_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        nst.done && !en |=> nst.done)
        else $error("normalize result dropped while the pipeline stalled");

endmodule

// ===== tb/qau_checker.sv =====
// Checker for the quaternion arithmetic unit: watches both channels, predicts each result
// beat from the accepted operation beat and compares field by field.
// Depends on qau_pkg and qau_if.
module qau_checker import qau_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    qau_in_if        i_in,
    qau_out_if       i_out,
    output int       o_fail_count,
    output int       o_pending
);

    typedef struct packed {
        logic signed [31:0] s;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic               sat;
    } t_quat_res;

    t_quat_res expected_q[$];
    logic clipped;

    assign o_pending = expected_q.size();

    function automatic logic signed [63:0] fx_mul(input logic signed [63:0] a,
                                                  input logic signed [63:0] b);
        logic signed [127:0] p;
        p = a * b;
        return 64'(p >>> FRAC_BITS);
    endfunction

    function automatic logic signed [63:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) begin
            clipped = 1'b1;
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648) begin
            clipped = 1'b1;
            return -64'sd2147483648;
        end
        return v;
    endfunction

    function automatic logic [63:0] isqrt(input logic [64:0] n);
        logic [64:0] root;
        logic [66:0] trial;
        root = 0;
        for (int i = 32; i >= 0; i--) begin
            trial = root | (67'd1 << i);
            if (trial * trial <= n) root = trial;
        end
        return root[63:0];
    endfunction

    function automatic logic signed [63:0] unit_comp(input logic signed [63:0] c,
                                                     input logic [63:0] m);
        logic [63:0] mag;
        logic [63:0] q;
        mag = (c < 0) ? 64'(-c) : 64'(c);
        q = (mag << FRAC_BITS) / m;
        return (c < 0) ? -$signed(q) : $signed(q);
    endfunction

    function automatic t_quat_res predict_quat(input logic [2:0] act,
                                               input logic signed [63:0] as_, ax, ay, az,
                                               input logic signed [63:0] bs, bx, by, bz);
        logic signed [63:0] rs, rx, ry, rz, t0, t1, t2, t3;
        logic [64:0] mag2;
        logic [63:0] m;
        t_quat_res r;
        clipped = 1'b0;
        rs = 0; rx = 0; ry = 0; rz = 0;
        case (act)
            ACT_MUL: begin
                rs = sat32(fx_mul(as_,bs) - fx_mul(ax,bx) - fx_mul(ay,by) - fx_mul(az,bz));
                rx = sat32(fx_mul(bs,ax) + fx_mul(as_,bx) + fx_mul(ay,bz) - fx_mul(az,by));
                ry = sat32(fx_mul(bs,ay) + fx_mul(as_,by) + fx_mul(az,bx) - fx_mul(ax,bz));
                rz = sat32(fx_mul(bs,az) + fx_mul(as_,bz) + fx_mul(ax,by) - fx_mul(ay,bx));
            end
            ACT_MUL_CB: begin
                rs = sat32(fx_mul(as_,bs) + fx_mul(ax,bx) + fx_mul(ay,by) + fx_mul(az,bz));
                rx = sat32(fx_mul(bs,ax) - fx_mul(as_,bx) - fx_mul(ay,bz) + fx_mul(az,by));
                ry = sat32(fx_mul(bs,ay) - fx_mul(as_,by) - fx_mul(az,bx) + fx_mul(ax,bz));
                rz = sat32(fx_mul(bs,az) - fx_mul(as_,bz) - fx_mul(ax,by) + fx_mul(ay,bx));
            end
            ACT_CA_MUL: begin
                rs = sat32(fx_mul(as_,bs) + fx_mul(ax,bx) + fx_mul(ay,by) + fx_mul(az,bz));
                rx = sat32(-fx_mul(bs,ax) + fx_mul(as_,bx) - fx_mul(ay,bz) + fx_mul(az,by));
                ry = sat32(-fx_mul(bs,ay) + fx_mul(as_,by) - fx_mul(az,bx) + fx_mul(ax,bz));
                rz = sat32(-fx_mul(bs,az) + fx_mul(as_,bz) - fx_mul(ax,by) + fx_mul(ay,bx));
            end
            ACT_ROT: begin
                t0 = sat32(fx_mul(ax,bx) + fx_mul(ay,by) + fx_mul(az,bz));
                t1 = sat32(fx_mul(as_,bx) + fx_mul(ay,bz) - fx_mul(az,by));
                t2 = sat32(fx_mul(as_,by) + fx_mul(az,bx) - fx_mul(ax,bz));
                t3 = sat32(fx_mul(as_,bz) + fx_mul(ax,by) - fx_mul(ay,bx));
                rx = sat32(fx_mul(t0,ax) + fx_mul(as_,t1) + fx_mul(ay,t3) - fx_mul(az,t2));
                ry = sat32(fx_mul(t0,ay) + fx_mul(as_,t2) + fx_mul(az,t1) - fx_mul(ax,t3));
                rz = sat32(fx_mul(t0,az) + fx_mul(as_,t3) + fx_mul(ax,t2) - fx_mul(ay,t1));
            end
            ACT_IROT: begin
                t0 = sat32(-fx_mul(ax,bx) - fx_mul(ay,by) - fx_mul(az,bz));
                t1 = sat32(fx_mul(as_,bx) - fx_mul(ay,bz) + fx_mul(az,by));
                t2 = sat32(fx_mul(as_,by) - fx_mul(az,bx) + fx_mul(ax,bz));
                t3 = sat32(fx_mul(as_,bz) - fx_mul(ax,by) + fx_mul(ay,bx));
                rx = sat32(-fx_mul(t0,ax) + fx_mul(as_,t1) - fx_mul(ay,t3) + fx_mul(az,t2));
                ry = sat32(-fx_mul(t0,ay) + fx_mul(as_,t2) - fx_mul(az,t1) + fx_mul(ax,t3));
                rz = sat32(-fx_mul(t0,az) + fx_mul(as_,t3) - fx_mul(ax,t2) + fx_mul(ay,t1));
            end
            ACT_NORM: begin
                mag2 = 65'(as_*as_) + 65'(ax*ax) + 65'(ay*ay) + 65'(az*az);
                m = isqrt(mag2);
                if (m == 0) begin
                    rs = 64'sd1 <<< FRAC_BITS;
                end else begin
                    rs = unit_comp(as_, m);
                    rx = unit_comp(ax, m);
                    ry = unit_comp(ay, m);
                    rz = unit_comp(az, m);
                end
            end
            default: ;
        endcase
        r.s = rs[31:0];
        r.x = rx[31:0];
        r.y = ry[31:0];
        r.z = rz[31:0];
        r.sat = clipped;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("checker: %s got %h expected %h at %0t", what, got, want, $realtime);
        o_fail_count++;
    endtask

    initial o_fail_count = 0;

    always @(posedge i_clk) begin
        t_quat_res want;
        if (i_rst_n) begin
            if (i_in.valid && i_in.ready) begin
                expected_q.push_back(predict_quat(i_in.action, i_in.a_s, i_in.a_x, i_in.a_y,
                    i_in.a_z, i_in.b_s, i_in.b_x, i_in.b_y, i_in.b_z));
            end
            if (i_out.valid && i_out.ready) begin
                if (expected_q.size() == 0) begin
                    report_mismatch("unexpected beat", i_out.r_s, 0);
                end else begin
                    want = expected_q.pop_front();
                    if (i_out.r_s !== want.s) report_mismatch("r_s", i_out.r_s, want.s);
                    if (i_out.r_x !== want.x) report_mismatch("r_x", i_out.r_x, want.x);
                    if (i_out.r_y !== want.y) report_mismatch("r_y", i_out.r_y, want.y);
                    if (i_out.r_z !== want.z) report_mismatch("r_z", i_out.r_z, want.z);
                    if (i_out.saturated !== want.sat) begin
                        report_mismatch("saturated", i_out.saturated, want.sat);
                    end
                end
            end
        end
    end

endmodule

// ===== tb/testbench.sv =====
// Top of the quaternion arithmetic unit testbench: clock, reset, operation beats and
// result-side stalls, with the verdict. Depends on qau_pkg, qau_if, qau_checker and the RTL.
module testbench import qau_pkg::*;;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   hold_off;

    qau_in_if  op_ch();
    qau_out_if res_ch();

    quaternion_arithmetic_unit_core i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (op_ch.sink),
        .o_out   (res_ch.source)
    );

    qau_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (op_ch),
        .i_out        (res_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic int gap_len();
        if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
        if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
        return 0;
    endfunction

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000 | ($urandom_range(0, 1) ? 32'h7fff_ffff : 32'h0);
            1: return $urandom_range(0, 1) ? 32'h0001_0000 : 32'hffff_0000;
            2: return $urandom();
            default: return 32'($signed($urandom_range(0, 32'h3_ffff)) - 32'sh2_0000);
        endcase
    endfunction

    task automatic send_op(input logic [2:0] act, input logic [31:0] w [8]);
        op_ch.valid  <= 1'b1;
        op_ch.action <= act;
        op_ch.a_s <= w[0]; op_ch.a_x <= w[1]; op_ch.a_y <= w[2]; op_ch.a_z <= w[3];
        op_ch.b_s <= w[4]; op_ch.b_x <= w[5]; op_ch.b_y <= w[6]; op_ch.b_z <= w[7];
        do @(posedge i_clk); while (!op_ch.ready);
    endtask

    task automatic idle_ops(input int n);
        if (n > 0) begin
            op_ch.valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    initial begin
        res_ch.ready = 1'b0;
        hold_off = 0;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (hold_off > 0) begin
                res_ch.ready <= 1'b0;
                hold_off--;
            end else if ($urandom_range(0, 3) == 0) begin
                res_ch.ready <= 1'b0;
                hold_off = gap_len();
            end else begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    initial begin
        logic [31:0] w [8];
        int waited;
        op_ch.valid = 1'b0;
        op_ch.action = ACT_MUL;
        op_ch.a_s = 0; op_ch.a_x = 0; op_ch.a_y = 0; op_ch.a_z = 0;
        op_ch.b_s = 0; op_ch.b_x = 0; op_ch.b_y = 0; op_ch.b_z = 0;
        i_rst_n = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        for (int act = 0; act < 8; act++) begin
            foreach (w[k]) w[k] = 32'h7fff_ffff;
            send_op(3'(act), w);
            foreach (w[k]) w[k] = 32'h8000_0000;
            send_op(3'(act), w);
        end
        foreach (w[k]) w[k] = 0;
        send_op(ACT_NORM, w);
        w[0] = 32'h0001_0000;
        w[5] = 32'h0002_0000;
        send_op(ACT_ROT, w);
        send_op(ACT_IROT, w);
        w[0] = 32'hffff_ffff;
        send_op(ACT_NORM, w);
        w[0] = 1;
        send_op(ACT_NORM, w);
        for (int n = 0; n < 1800; n++) begin
            if (n == 900) begin
                hold_off = 300;
            end
            foreach (w[k]) w[k] = rand_word();
            send_op(($urandom_range(0, 9) == 0) ? 3'($urandom_range(0, 7)) :
                    3'($urandom_range(0, 4)), w);
            if (n % 3 == 0 && $urandom_range(0, 3) == 0) send_op(ACT_NORM, w);
            if (n > 1000) idle_ops(gap_len());
        end
        op_ch.valid <= 1'b0;
        waited = 0;
        while (pending != 0 && waited < 100000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (200) @(posedge i_clk);
        if (pending == 0 && fail_count == 0) begin
            $display("quaternion_arithmetic_unit_core: match");
        end else begin
            $display("quaternion_arithmetic_unit_core: mismatch");
        end
        $finish;
    end

    initial begin
        #(12 * 2000000);
        $display("quaternion_arithmetic_unit_core: mismatch");
        $finish;
    end

endmodule

// ===== quaternion_arithmetic_unit_core.f =====
rtl/core/qau_pkg.sv
rtl/core/qau_if.sv
rtl/core/qau_front.sv
rtl/core/qau_norm.sv
rtl/core/qau_back.sv
rtl/core/quaternion_arithmetic_unit_core.sv
tb/qau_checker.sv
tb/testbench.sv
